### hdl/strs_pkg.sv
`timescale 1ns / 1ps
package strs_pkg;
    localparam int NumSpecies   = 1024;
    localparam int NumReactions = 1023;
    localparam int Levels       = 10;
    localparam int Leaves       = 1 << Levels;
    localparam int NodeW        = Levels + 1;
    localparam int KW           = Levels;
    localparam int PropW        = 43;
    localparam int CountW       = 17;
    localparam int RateW        = 16;
    localparam int InitW        = 7;
    localparam int FracW        = 16;
    localparam int CfgIdxW      = 1;
    localparam logic [CountW-1:0] CountMax = '1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgRate = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgInit = 1'b1;

    typedef enum logic [3:0] {
        ST_BUILD_LEAF,
        ST_BUILD_NODE,
        ST_IDLE,
        ST_MUL,
        ST_DESCEND,
        ST_FIRE,
        ST_PATH,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_frac;
        logic mul_step;
        logic desc_step;
        logic fire_step;
        logic path_step;
        logic build_leaf;
        logic build_node;
        logic init_ctrs;
        logic start_desc;
        logic start_path;
        logic set_out;
    } cmd_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic total_zero;
        logic mul_done;
        logic desc_done;
        logic fire_done;
        logic path_done;
        logic second_path;
        logic build_leaf_done;
        logic build_node_done;
    } status_t;
endpackage

### hdl/sum_tree_reaction_selector.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_random_fraction[15:0]
// m_        out        m_valid / m_ready    m_reaction_index, m_total_propensity, m_none_fired
// cfg_      in         cfg_valid/cfg_ready  cfg_index[0], cfg_data[15:0]
// One transaction at a time: a shift-add multiply, a descent from root to leaf,
// a count update and one or two leaf-to-root refreshes; a zero total returns
// after the multiply.
// After reset or a register write the tree is rebuilt, leaves first and then
// the inner nodes, with s_ready and cfg_ready low.
// The result holds in its register until m_ready takes it.
module sum_tree_reaction_selector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [strs_pkg::FracW-1:0]          s_random_fraction,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [strs_pkg::KW-1:0]             m_reaction_index,
    output logic [strs_pkg::PropW-1:0]          m_total_propensity,
    output logic                                m_none_fired,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [strs_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [strs_pkg::RateW-1:0]          cfg_data
);
    import strs_pkg::*;

    logic [RateW-1:0] rate_reg;
    logic [InitW-1:0] init_reg;
    logic             rebuild;
    cmd_t             cmd;
    status_t          status;

    assign rebuild = cfg_valid && cfg_ready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RateW'(6554);
            init_reg <= InitW'(100);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CfgRate: rate_reg <= cfg_data;
                CfgInit: init_reg <= cfg_data[InitW-1:0];
                default: rate_reg <= rate_reg;
            endcase
        end
    end

    strs_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .rebuild(rebuild),
        .s_fire(s_valid && s_ready), .m_fire(m_valid && m_ready),
        .status(status), .cmd(cmd), .s_ready(s_ready), .m_valid(m_valid),
        .cfg_ready(cfg_ready)
    );

    strs_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .rate_constant(rate_reg), .initial_count(init_reg),
        .frac_in(s_random_fraction), .k_out(m_reaction_index),
        .total_out(m_total_propensity), .zero_out(m_none_fired)
    );
endmodule

### hdl/strs_ram.sv
`timescale 1ns / 1ps
module strs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/strs_datapath.sv
`timescale 1ns / 1ps
module strs_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  strs_pkg::cmd_t                 cmd,
    output strs_pkg::status_t              status,
    input  logic [strs_pkg::RateW-1:0]     rate_constant,
    input  logic [strs_pkg::InitW-1:0]     initial_count,
    input  logic [strs_pkg::FracW-1:0]     frac_in,
    output logic [strs_pkg::KW-1:0]        k_out,
    output logic [strs_pkg::PropW-1:0]     total_out,
    output logic                           zero_out
);
    import strs_pkg::*;

    // Tree stored at 1-based heap index: root 1, leaves Leaves..2*Leaves-1.
    logic            t_we;
    logic [NodeW-1:0] t_waddr, t_raddr;
    logic [PropW-1:0] t_wdata, t_rdata;
    logic            c_we;
    logic [KW-1:0]   c_waddr, c_raddr;
    logic [CountW-1:0] c_wdata, c_rdata;

    strs_ram #(.Width(PropW), .Depth(2 * Leaves)) u_tree (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );
    strs_ram #(.Width(CountW), .Depth(NumSpecies)) u_count (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    logic [NodeW:0]    idx_reg, idx_next;     // build counter / node
    logic [3:0]        phase_reg, phase_next;
    logic [PropW-1:0]  acc_reg, acc_next;     // sum or target
    logic [PropW-1:0]  total_reg, total_next;
    logic [FracW-1:0]  frac_reg, frac_next;
    logic [PropW+FracW-1:0] prod_reg, prod_next;
    logic [4:0]        mcnt_reg, mcnt_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              second_reg, second_next;
    logic [KW:0]       pk_reg, pk_next;       // path leaf index (may be Leaves)
    logic              done_reg, done_next;
    logic              zero_reg, zero_next;

    // State registers; the controls and the build counter are reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            phase_reg  <= '0;
            done_reg   <= 1'b0;
            second_reg <= 1'b0;
            mcnt_reg   <= '0;
        end else begin
            idx_reg    <= idx_next;
            phase_reg  <= phase_next;
            done_reg   <= done_next;
            second_reg <= second_next;
            mcnt_reg   <= mcnt_next;
        end
        acc_reg   <= acc_next;
        total_reg <= total_next;
        frac_reg  <= frac_next;
        prod_reg  <= prod_next;
        k_reg     <= k_next;
        pk_reg    <= pk_next;
        zero_reg  <= zero_next;
    end

    logic [RateW+CountW-1:0] leaf_prop;
    logic [CountW-1:0]       cnt_mod;

    always_comb begin
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        total_next  = total_reg;
        frac_next   = frac_reg;
        prod_next   = prod_reg;
        mcnt_next   = mcnt_reg;
        k_next      = k_reg;
        second_next = second_reg;
        pk_next     = pk_reg;
        done_next   = 1'b0;
        zero_next   = zero_reg;
        t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        leaf_prop = '0;
        cnt_mod = c_rdata;

        if (cmd.init_ctrs) begin
            idx_next   = (NodeW+1)'(0);
            phase_next = '0;
        end
        // Rebuild leaves: counts reset, leaf holds rate*count (zero beyond the last reaction).
        if (cmd.build_leaf) begin
            leaf_prop = rate_constant * CountW'(initial_count);
            c_we = (idx_reg < (NodeW+1)'(NumSpecies));
            c_waddr = idx_reg[KW-1:0];
            c_wdata = CountW'(initial_count);
            t_we = 1'b1;
            t_waddr = NodeW'(Leaves) + idx_reg[NodeW-1:0];
            t_wdata = (idx_reg < (NodeW+1)'(NumReactions) &&
                       idx_reg < (NodeW+1)'(NumSpecies)) ? PropW'(leaf_prop) : '0;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == (NodeW+1)'(Leaves - 1)) begin
                idx_next = (NodeW+1)'(Leaves - 1);
                done_next = 1'b1;
            end
        end
        // Rebuild inner nodes, downward index: read two children, write sum.
        if (cmd.build_node) begin
            case (phase_reg)
                4'd0: begin
                    t_raddr = {idx_reg[NodeW-2:0], 1'b0};
                    phase_next = 4'd1;
                end
                4'd1: begin
                    acc_next = t_rdata;
                    t_raddr = {idx_reg[NodeW-2:0], 1'b1};
                    phase_next = 4'd2;
                end
                default: begin
                    t_we = 1'b1;
                    t_waddr = idx_reg[NodeW-1:0];
                    t_wdata = acc_reg + t_rdata;
                    phase_next = 4'd0;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == (NodeW+1)'(1)) begin
                        done_next = 1'b1;
                    end
                end
            endcase
        end
        // Load fraction and read root.
        if (cmd.load_frac) begin
            frac_next = frac_in;
            t_raddr = NodeW'(1);
            mcnt_next = '0;
            prod_next = '0;
        end
        // Shift-add multiply, one fraction bit per cycle, MSB first.
        if (cmd.mul_step) begin
            if (mcnt_reg == 5'd0) begin
                total_next = t_rdata;
                zero_next = (t_rdata == '0);
                prod_next = frac_reg[FracW-1] ? (PropW+FracW)'(t_rdata) : '0;
            end else begin
                prod_next = {prod_reg[PropW+FracW-2:0], 1'b0} +
                    (frac_reg[FracW-1] ? (PropW+FracW)'(total_reg) : '0);
            end
            frac_next = {frac_reg[FracW-2:0], 1'b0};
            mcnt_next = mcnt_reg + 1'b1;
            if (mcnt_reg == 5'(FracW - 1)) begin
                done_next = 1'b1;
            end
        end
        if (cmd.start_desc) begin
            acc_next = prod_reg[PropW+FracW-1:FracW];
            idx_next = (NodeW+1)'(1);
            phase_next = '0;
        end
        // Descent: read left child, then compare; stop once a leaf is reached.
        if (cmd.desc_step) begin
            case (phase_reg)
                4'd0: begin
                    t_raddr = {idx_reg[NodeW-2:0], 1'b0};
                    phase_next = 4'd1;
                end
                default: begin
                    if (acc_reg < t_rdata) begin
                        idx_next = {idx_reg[NodeW-1:0], 1'b0};
                    end else begin
                        acc_next = acc_reg - t_rdata;
                        idx_next = {idx_reg[NodeW-1:0], 1'b1};
                    end
                    phase_next = 4'd0;
                    if (idx_reg[NodeW-2]) begin
                        done_next = 1'b1;
                    end
                end
            endcase
        end
        // Fire: update the two counts.
        if (cmd.fire_step) begin
            case (phase_reg)
                4'd0: begin
                    k_next = idx_reg[KW-1:0];
                    c_raddr = idx_reg[KW-1:0];
                    phase_next = 4'd1;
                end
                4'd1: begin
                    cnt_mod = (c_rdata != '0) ? c_rdata - 1'b1 : c_rdata;
                    c_we = ({1'b0, k_reg} < (KW+1)'(NumSpecies));
                    c_waddr = k_reg;
                    c_wdata = cnt_mod;
                    c_raddr = k_reg + 1'b1;
                    phase_next = 4'd2;
                end
                default: begin
                    cnt_mod = (c_rdata != CountMax) ? c_rdata + 1'b1 : c_rdata;
                    c_we = ({1'b0, k_reg} + 1'b1 < (KW+1)'(NumSpecies));
                    c_waddr = k_reg + 1'b1;
                    c_wdata = cnt_mod;
                    phase_next = 4'd0;
                    second_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
        if (cmd.start_path) begin
            pk_next = second_reg ? {1'b0, k_reg} + 1'b1 : {1'b0, k_reg};
            phase_next = '0;
        end
        // Path refresh: leaf from count, then parents via sibling reads.
        if (cmd.path_step) begin
            case (phase_reg)
                4'd0: begin
                    c_raddr = pk_reg[KW-1:0];
                    phase_next = 4'd1;
                end
                4'd1: begin
                    c_raddr = pk_reg[KW-1:0];
                    phase_next = 4'd2;
                end
                4'd2: begin
                    leaf_prop = rate_constant * c_rdata;
                    acc_next = (pk_reg < (KW+1)'(NumReactions) &&
                                pk_reg < (KW+1)'(NumSpecies)) ? PropW'(leaf_prop) : '0;
                    idx_next = {1'b0, NodeW'(Leaves) + pk_reg[KW-1:0]};
                    phase_next = 4'd3;
                end
                4'd3: begin
                    t_we = 1'b1;
                    t_waddr = idx_reg[NodeW-1:0];
                    t_wdata = acc_reg;
                    t_raddr = idx_reg[NodeW-1:0] ^ NodeW'(1);
                    phase_next = 4'd4;
                    if (idx_reg == (NodeW+1)'(1)) begin
                        done_next = 1'b1;
                        second_next = 1'b1;
                        phase_next = 4'd0;
                    end
                end
                4'd4: begin
                    t_raddr = idx_reg[NodeW-1:0] ^ NodeW'(1);
                    phase_next = 4'd5;
                end
                default: begin
                    acc_next = acc_reg + t_rdata;
                    idx_next = idx_reg >> 1;
                    phase_next = 4'd3;
                end
            endcase
        end
    end

    assign status.total_zero      = zero_reg;
    assign status.mul_done        = done_reg;
    assign status.desc_done       = done_reg;
    assign status.fire_done       = done_reg;
    assign status.path_done       = done_reg;
    assign status.build_leaf_done = done_reg;
    assign status.build_node_done = done_reg;
    assign status.second_path     = ({1'b0, k_reg} + 1'b1 < (KW+1)'(NumReactions));

    assign k_out     = zero_reg ? '0 : k_reg;
    assign total_out = zero_reg ? '0 : total_reg;
    assign zero_out  = zero_reg;
endmodule

### hdl/strs_ctrl.sv
`timescale 1ns / 1ps
module strs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rebuild,
    input  logic              s_fire,
    input  logic              m_fire,
    input  strs_pkg::status_t status,
    output strs_pkg::cmd_t    cmd,
    output logic              s_ready,
    output logic              m_valid,
    output logic              cfg_ready
);
    import strs_pkg::*;

    state_t state_reg, state_next;
    logic   path2_reg, path2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BUILD_LEAF;
            path2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            path2_reg <= path2_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        path2_next = path2_reg;
        case (state_reg)
            ST_BUILD_LEAF: if (status.build_leaf_done) state_next = ST_BUILD_NODE;
            ST_BUILD_NODE: if (status.build_node_done) state_next = ST_IDLE;
            ST_IDLE: begin
                if (rebuild) begin
                    state_next = ST_BUILD_LEAF;
                end else if (s_fire) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: if (status.mul_done) begin
                state_next = status.total_zero ? ST_OUT : ST_DESCEND;
            end
            ST_DESCEND: if (status.desc_done) state_next = ST_FIRE;
            ST_FIRE: if (status.fire_done) begin
                state_next = ST_PATH;
                path2_next = 1'b0;
            end
            ST_PATH: if (status.path_done) begin
                if (!path2_reg && status.second_path) begin
                    path2_next = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: if (m_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs; the descent and path start pulses fire on the cycle before that phase begins.
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        cfg_ready = 1'b0;
        case (state_reg)
            ST_BUILD_LEAF: cmd.build_leaf = !status.build_leaf_done;
            ST_BUILD_NODE: cmd.build_node = !status.build_node_done;
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready = !rebuild;
                cmd.load_frac = 1'b1;
                cmd.init_ctrs = 1'b1;
            end
            ST_MUL: begin
                cmd.mul_step = !status.mul_done;
                cmd.start_desc = status.mul_done;
            end
            ST_DESCEND: cmd.desc_step = !status.desc_done;
            ST_FIRE: begin
                cmd.fire_step = !status.fire_done;
                cmd.start_path = status.fire_done;
            end
            ST_PATH: begin
                cmd.path_step = !status.path_done;
                cmd.start_path = status.path_done;
            end
            ST_OUT: m_valid = 1'b1;
            default: cmd = '0;
        endcase
    end
endmodule

### test/sum_tree_reaction_selector_tb.sv
`timescale 1ns / 1ps
module sum_tree_reaction_selector_tb;
    import strs_pkg::*;

    localparam int TreeNodes = 2 * Leaves - 1;
    localparam int NumRandom = 1900;

    typedef struct packed {
        logic [KW-1:0]    reaction_index;
        logic [PropW-1:0] total_propensity;
        logic             none_fired;
    } selection_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FracW-1:0] s_random_fraction = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [KW-1:0] m_reaction_index;
    logic [PropW-1:0] m_total_propensity;
    logic m_none_fired;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [RateW-1:0] cfg_data = '0;

    // Model state: counts, sum tree and registers.
    logic [CountW-1:0] model_count [NumSpecies];
    logic [PropW-1:0]  model_tree [TreeNodes];
    logic [RateW-1:0]  model_rate;
    logic [InitW-1:0]  model_init;

    logic [FracW-1:0] pending_fractions [$];
    selection_t       expected_selections [$];
    int errors = 0;
    int accepted = 0;
    int received = 0;
    int zero_totals = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit input_taken = 1'b0;

    sum_tree_reaction_selector u_top (.*);

    always #2 aclk = ~aclk;

    function automatic logic [PropW-1:0] leaf_propensity(int k);
        if (k >= NumReactions || k >= NumSpecies) return '0;
        return PropW'(model_rate) * PropW'(model_count[k]);
    endfunction

    function automatic void refresh_leaf(int k);
        int node;
        node = Leaves - 1 + k;
        model_tree[node] = leaf_propensity(k);
        while (node > 0) begin
            node = (node - 1) / 2;
            model_tree[node] = model_tree[2 * node + 1] + model_tree[2 * node + 2];
        end
    endfunction

    task automatic rebuild_tree();
        for (int i = 0; i < NumSpecies; i++) model_count[i] = CountW'(model_init);
        for (int i = 0; i < Leaves; i++) model_tree[Leaves - 1 + i] = leaf_propensity(i);
        for (int i = Leaves - 2; i >= 0; i--)
            model_tree[i] = model_tree[2 * i + 1] + model_tree[2 * i + 2];
    endtask

    // Pick a reaction from the fraction and apply it to the model.
    function automatic selection_t select_reaction(logic [FracW-1:0] frac);
        selection_t res;
        logic [PropW+FracW-1:0] product;
        logic [PropW-1:0] target;
        logic [PropW-1:0] total_before;
        int node;
        int k;
        res = '0;
        total_before = model_tree[0];
        if (total_before == '0) begin
            res.none_fired = 1'b1;
            return res;
        end
        product = (PropW + FracW)'(frac) * (PropW + FracW)'(total_before);
        target = PropW'(product >> FracW);
        node = 0;
        while (node < Leaves - 1) begin
            if (target < model_tree[2 * node + 1]) begin
                node = 2 * node + 1;
            end else begin
                target = target - model_tree[2 * node + 1];
                node = 2 * node + 2;
            end
        end
        k = node - (Leaves - 1);
        if (k < NumSpecies && model_count[k] > 0) model_count[k]--;
        if (k + 1 < NumSpecies && model_count[k + 1] < CountMax) model_count[k + 1]++;
        refresh_leaf(k);
        if (k + 1 < NumReactions) refresh_leaf(k + 1);
        res.reaction_index = KW'(k);
        res.total_propensity = total_before;
        return res;
    endfunction

    // Driver: bursts of transactions with random gaps.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (input_taken || !s_valid) begin
                if (input_taken) begin
                    pending_fractions.pop_front();
                end
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_fractions.size() > 0) begin
                    s_valid <= 1'b1;
                    s_random_fraction <= pending_fractions[0];
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            // Receiver stalls on a repeating pattern, with a random part.
            stall_phase <= (stall_phase + 1) % 64;
            m_ready <= stall_phase < 16 ? 1'b1 : (stall_phase < 40 ? $urandom_range(0, 2) != 0
                                                             : $urandom_range(0, 3) == 0);
        end
    end

    // Monitor: predict on input transactions, check result transactions.
    always @(posedge aclk) begin
        selection_t want;
        input_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = select_reaction(s_random_fraction);
                expected_selections.push_back(want);
                accepted++;
            end
            if (m_valid && m_ready) begin
                received++;
                if (m_none_fired) zero_totals++;
                if (expected_selections.size() == 0) begin
                    $error("result transaction with nothing expected");
                    errors++;
                end else begin
                    want = expected_selections.pop_front();
                    if (m_reaction_index !== want.reaction_index) begin
                        $error("reaction_index expected %0d actual %0d",
                               want.reaction_index, m_reaction_index);
                        errors++;
                    end
                    if (m_total_propensity !== want.total_propensity) begin
                        $error("total_propensity expected %0d actual %0d",
                               want.total_propensity, m_total_propensity);
                        errors++;
                    end
                    if (m_none_fired !== want.none_fired) begin
                        $error("none_fired expected %0d actual %0d",
                               want.none_fired, m_none_fired);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_register(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        if (idx == CfgRate) model_rate = value;
        else model_init = InitW'(value);
        rebuild_tree();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int count);
        for (int i = 0; i < count; i++) pending_fractions.push_back(FracW'($urandom));
        wait (pending_fractions.size() == 0 && !s_valid);
        wait (expected_selections.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        model_rate = 16'd6554;
        model_init = 7'd100;
        rebuild_tree();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: field extremes, saturation-prone fractions.
        pending_fractions = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF,
                              16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
        run_phase(300);
        // Zero rate: every step returns the zero-total result.
        write_register(CfgRate, 16'd0);
        run_phase(20);
        // Largest rate and count, then a zero count, then a count of one that drains quickly.
        write_register(CfgRate, 16'hFFFF);
        write_register(CfgInit, 16'd127);
        run_phase(500);
        write_register(CfgInit, 16'd0);
        run_phase(20);
        write_register(CfgInit, 16'd1);
        write_register(CfgRate, 16'd1);
        run_phase(500);
        write_register(CfgRate, 16'h8001);
        write_register(CfgInit, 16'd64);
        run_phase(NumRandom - 1340);
        $display("Sent %0d fractions and checked %0d selections (%0d with zero total)",
                 accepted, received, zero_totals);
        $display("across six rate and count settings.");
        if (errors == 0 && expected_selections.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
